// ===== rtl/octree_key_encoder_unit_assert.svh =====
// Assertion macros for the octree key encoder checker.
`ifndef OCTREE_KEY_ENCODER_UNIT_ASSERT_SVH
`define OCTREE_KEY_ENCODER_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define OKEY_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("octree key encoder check failed");

// Clocked assertion that also holds through reset.
`define OKEY_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("octree key encoder check failed");

`endif

// ===== rtl/okey_pkg.sv =====
package okey_pkg;

  localparam int COORD_W = 32;
  localparam int SIDE_W  = 31;
  localparam int KEY_W   = 30;
  localparam int OCT_W   = 3;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 31'd65536;

endpackage

// ===== rtl/okey_point_if.sv =====
interface okey_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [okey_pkg::COORD_W-1:0] coord_x;
  logic signed [okey_pkg::COORD_W-1:0] coord_y;
  logic signed [okey_pkg::COORD_W-1:0] coord_z;
  logic                              batch_end;

  modport source (output valid, coord_x, coord_y, coord_z, batch_end, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, batch_end, output ready);
endinterface

// ===== rtl/okey_key_if.sv =====
interface okey_key_if;
  logic                          valid;
  logic                          ready;
  logic [okey_pkg::KEY_W-1:0]    cell_key;
  logic                          batch_end_out;

  modport source (output valid, cell_key, batch_end_out, input ready);
  modport sink   (input valid, cell_key, batch_end_out, output ready);
endinterface

// ===== rtl/okey_cfg_if.sv =====
interface okey_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [okey_pkg::SIDE_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/okey_level.sv =====
// One octree level: compare each residual with the half side, set the
// octant bit and drop the half where the point lies in the upper child.
module okey_level #(
  parameter int W     = 42,
  parameter int KW    = 30,
  parameter int SHIFT = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_in,
  input  logic signed [W-1:0]         rx_in,
  input  logic signed [W-1:0]         ry_in,
  input  logic signed [W-1:0]         rz_in,
  input  logic [KW-1:0]               key_in,
  input  logic                        be_in,
  input  logic [okey_pkg::SIDE_W-1:0] box_side,
  output logic                        valid,
  output logic signed [W-1:0]         rx,
  output logic signed [W-1:0]         ry,
  output logic signed [W-1:0]         rz,
  output logic [KW-1:0]               key,
  output logic                        be
);

  logic signed [W-1:0]           half;
  logic [okey_pkg::OCT_W-1:0]    oct;

  // half side at this level, scaled so it is always an integer
  assign half = $signed(W'(box_side) << SHIFT);

  assign oct[0] = (rx_in >= half);
  assign oct[1] = (ry_in >= half);
  assign oct[2] = (rz_in >= half);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx  <= oct[0] ? rx_in - half : rx_in;
      ry  <= oct[1] ? ry_in - half : ry_in;
      rz  <= oct[2] ? rz_in - half : rz_in;
      key <= KW'({key_in, oct});
      be  <= be_in;
    end
  end

endmodule

// ===== rtl/octree_key_encoder_unit.sv =====
// Octree key encoder: each point beat on points yields one key beat on keys,
// in order. One pipeline stage per octree level follows an input register,
// so a point passes the input register, then each level stage, before its
// key shows on keys; a new point is taken every cycle while keys is drained.
// Each level stage holds one compare-and-subtract per axis on residuals of
// 32 + KEY_LEVELS bits. Stages with no valid beat fill in under a stall, so
// points.ready falls only once every stage holds a beat. box_side is written
// through cfg (always ready) and must only change while the pipeline is empty.
module octree_key_encoder_unit #(
  parameter int KEY_LEVELS = 10
) (
  input  logic         clk,
  input  logic         rst,
  okey_point_if.sink   points,
  okey_key_if.source   keys,
  okey_cfg_if.sink     cfg
);

  localparam int L  = KEY_LEVELS;
  localparam int W  = okey_pkg::COORD_W + L;
  localparam int KW = okey_pkg::OCT_W * L;

  logic [okey_pkg::SIDE_W-1:0] box_side;

  logic                v  [0:L];
  logic                en [0:L];
  logic signed [W-1:0] rx [0:L];
  logic signed [W-1:0] ry [0:L];
  logic signed [W-1:0] rz [0:L];
  logic [KW-1:0]       key[0:L];
  logic                be [0:L];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_side <= okey_pkg::SIDE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      box_side <= cfg.data;
    end
  end

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    en[L] = !v[L] || keys.ready;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign points.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= points.valid;
    end
  end

  // scale coordinates by 2^L so every halving of the side stays exact
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx[0] <= {points.coord_x, {L{1'b0}}};
      ry[0] <= {points.coord_y, {L{1'b0}}};
      rz[0] <= {points.coord_z, {L{1'b0}}};
      be[0] <= points.batch_end;
    end
  end

  assign key[0] = '0;

  for (genvar k = 1; k <= L; k++) begin : g_level
    okey_level #(
      .W     (W),
      .KW    (KW),
      .SHIFT (L - k)
    ) u_level (
      .clk      (clk),
      .rst      (rst),
      .en       (en[k]),
      .valid_in (v[k-1]),
      .rx_in    (rx[k-1]),
      .ry_in    (ry[k-1]),
      .rz_in    (rz[k-1]),
      .key_in   (key[k-1]),
      .be_in    (be[k-1]),
      .box_side (box_side),
      .valid    (v[k]),
      .rx       (rx[k]),
      .ry       (ry[k]),
      .rz       (rz[k]),
      .key      (key[k]),
      .be       (be[k])
    );
  end

  assign keys.valid         = v[L];
  assign keys.cell_key      = okey_pkg::KEY_W'(key[L]);
  assign keys.batch_end_out = be[L];

endmodule

// ===== rtl/okey_checker.sv =====
`include "octree_key_encoder_unit_assert.svh"

module okey_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [okey_pkg::KEY_W-1:0] out_key,
  input logic                       cfg_ready
);

  // a stalled key beat stays put
  `OKEY_ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_key))

  // an empty or draining output means the whole pipeline can advance
  `OKEY_ASSERT_CLK(a_ready_flow, clk, rst, (!out_valid || out_ready) |-> in_ready)

  // nothing comes out right after reset
  `OKEY_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // register writes are never held off
  `OKEY_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready)

endmodule

bind octree_key_encoder_unit okey_checker u_okey_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (points.ready),
  .out_valid (keys.valid),
  .out_ready (keys.ready),
  .out_key   (keys.cell_key),
  .cfg_ready (cfg.ready)
);
